/* hw/rtl/multi_pattern_string_matcher_assert.svh */
// Assertion macros used by the checker of the string matcher.
`ifndef MULTI_PATTERN_STRING_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_STRING_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MPSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mpsm_pkg.sv */
// Shared constants and codes of the multi-pattern string matcher.
package mpsm_pkg;

  localparam int ALPHABET_DEF     = 4;
  localparam int MAX_STATES_DEF   = 1024;
  localparam int MAX_PATTERNS_DEF = 256;
  localparam int OPS_DEF          = 4;

  localparam logic [8:0] PCOUNT_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STATES_FULL = 3'd1,
    ST_OUTPUT_FULL = 3'd2,
    ST_PHASE       = 3'd3,
    ST_RANGE       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_SCAN  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

endpackage

/* hw/rtl/multi_pattern_string_matcher.sv */
// Aho-Corasick matcher: trie insert, link build, scan and counter read on one sequencer.
//
// Usage: drive mode_i, symbol_i, pattern_id_i and last_symbol_i with start high while
// busy is low; the word is taken at that edge. Exactly one result word follows, shown
// for one cycle on status_o, current_state_o, matches_here_o and hit_count_o with
// done_o high. The receiver cannot stall, so results are never held back.
// The one configuration register, pattern_count, is written with cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle; the block does not enforce this.
// Words that fail a phase or range check answer in the cycle after start and leave
// the block idle. A scan follows failure links until a goto entry exists, then visits
// each pattern id listed at the new state. A build walks the trie breadth first: each
// root symbol, then per queued state a queue check and each child symbol, following
// failure hops and copying ids for the present ones, then a final queue check and a
// counter clear. Every memory has one read and one write port. Reset: a clearing pass
// empties the goto table, links, list lengths and counters; busy stays high during it.
module multi_pattern_string_matcher #(
  parameter int ALPHABET          = mpsm_pkg::ALPHABET_DEF,
  parameter int MAX_STATES        = mpsm_pkg::MAX_STATES_DEF,
  parameter int MAX_PATTERNS      = mpsm_pkg::MAX_PATTERNS_DEF,
  parameter int OUTPUTS_PER_STATE = mpsm_pkg::OPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  symbol_i,
  input  logic [7:0]  pattern_id_i,
  input  logic        last_symbol_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [9:0]  current_state_o,
  output logic [2:0]  matches_here_o,
  output logic [31:0] hit_count_o
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int AW    = $clog2(ALPHABET);
  localparam int GD    = MAX_STATES * ALPHABET;
  localparam int GW    = $clog2(GD);
  localparam int ID    = MAX_STATES * OUTPUTS_PER_STATE;
  localparam int IDW   = $clog2(ID);
  localparam int LW    = $clog2(OUTPUTS_PER_STATE + 1);
  localparam int PW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CLR_N = (GD > MAX_PATTERNS) ? GD : MAX_PATTERNS;
  localparam int CLW   = $clog2(CLR_N) + 1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_A_CHK, S_A_LEN, S_R_CNT,
    S_S_GCHK, S_S_FAIL, S_S_LEN, S_S_ID, S_S_CNT,
    S_B_RTC, S_B_QCHK, S_B_QR, S_B_F, S_B_G, S_B_FW, S_B_FF,
    S_B_LF, S_B_LC, S_B_ID, S_B_CLR
  } state_e;

  // Memories
  logic [SW:0]   goto_mem [GD];
  logic [SW-1:0] fail_mem [MAX_STATES];
  logic [LW-1:0] len_mem  [MAX_STATES];
  logic [7:0]    ids_mem  [ID];
  logic [SW-1:0] queue_mem[MAX_STATES];
  logic [31:0]   hit_mem  [MAX_PATTERNS];

  logic [SW:0]   g_rd_q;
  logic [SW-1:0] f_rd_q, q_rd_q;
  logic [LW-1:0] l_rd_q;
  logic [7:0]    i_rd_q;
  logic [31:0]   h_rd_q;

  logic           g_we, f_we, l_we, i_we, q_we, h_we;
  logic [GW-1:0]  g_ra, g_wa;
  logic [SW:0]    g_wd;
  logic [SW-1:0]  f_ra, f_wa, f_wd, l_ra, l_wa, q_ra, q_wa, q_wd;
  logic [LW-1:0]  l_wd;
  logic [IDW-1:0] i_ra, i_wa;
  logic [7:0]     i_wd;
  logic [PW-1:0]  h_ra, h_wa;
  logic [31:0]    h_wd;

  // Control and payload registers
  state_e            state_q, state_d;
  logic [CLW-1:0]    clr_q, clr_d;
  logic [8:0]        pcnt_q, pcnt_d;
  logic [SW:0]       nfs_q, nfs_d, head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]     cur_q, cur_d, scan_q, scan_d, s_q, s_d;
  logic [SW-1:0]     r_q, r_d, c_q, c_d, f_q, f_d, fr_q, fr_d;
  logic              built_q, built_d, last_q, last_d, bst_q, bst_d;
  logic [AW-1:0]     a_q, a_d;
  logic [7:0]        pid_q, pid_d;
  logic [LW-1:0]     n_q, n_d, k_q, k_d, lf_q, lf_d;
  logic [PW-1:0]     id_q, id_d;
  logic              done_q, done_d;
  mpsm_pkg::status_e status_q, status_d;
  logic [9:0]        cs_q, cs_d;
  logic [2:0]        mh_q, mh_d;
  logic [31:0]       hc_q, hc_d;

  logic [12:0] used;
  logic        sym_ok;

  function automatic logic [GW-1:0] gaddr(input logic [SW-1:0] s, input logic [AW-1:0] a);
    return GW'(s) * GW'(ALPHABET) + GW'(a);
  endfunction

  function automatic logic [IDW-1:0] iaddr(input logic [SW-1:0] s, input logic [LW-1:0] k);
    return IDW'(s) * IDW'(OUTPUTS_PER_STATE) + IDW'(k);
  endfunction

  function automatic logic [9:0] show(input logic [SW-1:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[9:0];
  endfunction

  function automatic logic [2:0] cnt3(input logic [LW-1:0] n);
    logic [7:0] w;
    w = 8'(n);
    return w[2:0];
  endfunction

  assign used   = (13'(pcnt_q) < 13'(MAX_PATTERNS)) ? 13'(pcnt_q) : 13'(MAX_PATTERNS);
  assign sym_ok = 9'(symbol_i) < 9'(ALPHABET);
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    logic [SW-1:0] snew;
    logic [LW-1:0] bn, bk, kn;
    logic          bstep, adv_a, sstep;
    state_d  = state_q;  clr_d  = clr_q;  pcnt_d  = pcnt_q;  nfs_d = nfs_q;
    head_d   = head_q;   tail_d = tail_q; cur_d   = cur_q;   scan_d = scan_q;
    s_d      = s_q;      r_d    = r_q;    c_d     = c_q;     f_d = f_q;   fr_d = fr_q;
    built_d  = built_q;  last_d = last_q; bst_d   = bst_q;   a_d = a_q;
    pid_d    = pid_q;    n_d    = n_q;    k_d     = k_q;     lf_d = lf_q; id_d = id_q;
    done_d   = 1'b0;     status_d = mpsm_pkg::ST_OK;
    cs_d     = '0;       mh_d   = '0;     hc_d    = '0;
    g_we = 1'b0; g_ra = '0; g_wa = '0; g_wd = '0;
    f_we = 1'b0; f_ra = '0; f_wa = '0; f_wd = '0;
    l_we = 1'b0; l_ra = '0; l_wa = '0; l_wd = '0;
    i_we = 1'b0; i_ra = '0; i_wa = '0; i_wd = '0;
    q_we = 1'b0; q_ra = '0; q_wa = '0; q_wd = '0;
    h_we = 1'b0; h_ra = '0; h_wa = '0; h_wd = '0;
    snew = '0; bn = '0; bk = '0; kn = '0;
    bstep = 1'b0; adv_a = 1'b0; sstep = 1'b0;

    if (cfg_we_i) begin
      pcnt_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_INIT: begin
        if (clr_q < CLW'(GD)) begin
          g_we = 1'b1; g_wa = clr_q[GW-1:0];
        end
        if (clr_q < CLW'(MAX_STATES)) begin
          f_we = 1'b1; f_wa = clr_q[SW-1:0];
          l_we = 1'b1; l_wa = clr_q[SW-1:0];
        end
        if (clr_q < CLW'(MAX_PATTERNS)) begin
          h_we = 1'b1; h_wa = clr_q[PW-1:0];
        end
        if (clr_q == CLW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          pid_d  = pattern_id_i;
          last_d = last_symbol_i;
          a_d    = AW'(symbol_i);
          unique case (mpsm_pkg::mode_e'(mode_i))
            mpsm_pkg::MODE_ADD: begin
              if (built_q || !sym_ok) begin
                done_d   = 1'b1;
                status_d = built_q ? mpsm_pkg::ST_PHASE : mpsm_pkg::ST_RANGE;
                cs_d     = show(cur_q);
              end else begin
                g_ra    = gaddr(cur_q, AW'(symbol_i));
                state_d = S_A_CHK;
              end
            end
            mpsm_pkg::MODE_BUILD: begin
              if (built_q) begin
                done_d   = 1'b1;
                status_d = mpsm_pkg::ST_PHASE;
              end else begin
                a_d     = '0;
                head_d  = '0;
                tail_d  = '0;
                bst_d   = 1'b0;
                g_ra    = gaddr('0, '0);
                state_d = S_B_RTC;
              end
            end
            mpsm_pkg::MODE_SCAN: begin
              if (!built_q || !sym_ok) begin
                done_d   = 1'b1;
                status_d = !built_q ? mpsm_pkg::ST_PHASE : mpsm_pkg::ST_RANGE;
                cs_d     = show(scan_q);
              end else begin
                s_d     = scan_q;
                g_ra    = gaddr(scan_q, AW'(symbol_i));
                state_d = S_S_GCHK;
              end
            end
            mpsm_pkg::MODE_READ: begin
              if (13'(pattern_id_i) < used) begin
                h_ra    = PW'(pattern_id_i);
                state_d = S_R_CNT;
              end else begin
                done_d   = 1'b1;
                status_d = mpsm_pkg::ST_RANGE;
                cs_d     = show(scan_q);
              end
            end
          endcase
        end
      end
      S_A_CHK: begin
        state_d = S_IDLE;
        if (!g_rd_q[SW] && nfs_q >= (SW+1)'(MAX_STATES)) begin
          done_d   = 1'b1;
          status_d = mpsm_pkg::ST_STATES_FULL;
          cs_d     = show(cur_q);
          cur_d    = '0;
        end else begin
          if (!g_rd_q[SW]) begin
            snew = SW'(nfs_q);
            g_we = 1'b1; g_wa = gaddr(cur_q, a_q); g_wd = {1'b1, snew};
            nfs_d = nfs_q + 1'b1;
          end else begin
            snew = g_rd_q[SW-1:0];
          end
          if (!last_q) begin
            cur_d  = snew;
            done_d = 1'b1;
            cs_d   = show(snew);
          end else begin
            cur_d   = '0;
            s_d     = snew;
            l_ra    = snew;
            state_d = S_A_LEN;
          end
        end
      end
      S_A_LEN: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        cs_d    = show(s_q);
        if (l_rd_q >= LW'(OUTPUTS_PER_STATE)) begin
          status_d = mpsm_pkg::ST_OUTPUT_FULL;
        end else begin
          i_we = 1'b1; i_wa = iaddr(s_q, l_rd_q); i_wd = pid_q;
          l_we = 1'b1; l_wa = s_q; l_wd = l_rd_q + 1'b1;
        end
      end
      S_R_CNT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        cs_d    = show(scan_q);
        hc_d    = h_rd_q;
      end
      S_S_GCHK: begin
        if (g_rd_q[SW]) begin
          s_d     = g_rd_q[SW-1:0];
          scan_d  = g_rd_q[SW-1:0];
          l_ra    = g_rd_q[SW-1:0];
          state_d = S_S_LEN;
        end else begin
          f_ra    = s_q;
          state_d = S_S_FAIL;
        end
      end
      S_S_FAIL: begin
        s_d     = f_rd_q;
        g_ra    = gaddr(f_rd_q, a_q);
        state_d = S_S_GCHK;
      end
      S_S_LEN: begin
        n_d = l_rd_q;
        k_d = '0;
        if (l_rd_q == '0) begin
          done_d  = 1'b1;
          cs_d    = show(s_q);
          state_d = S_IDLE;
        end else begin
          i_ra    = iaddr(s_q, '0);
          state_d = S_S_ID;
        end
      end
      S_S_ID: begin
        if (13'(i_rd_q) < used) begin
          id_d    = PW'(i_rd_q);
          h_ra    = PW'(i_rd_q);
          state_d = S_S_CNT;
        end else begin
          sstep = 1'b1;
        end
      end
      S_S_CNT: begin
        h_we  = 1'b1;
        h_wa  = id_q;
        h_wd  = (h_rd_q == '1) ? h_rd_q : h_rd_q + 32'd1;
        sstep = 1'b1;
      end
      S_B_RTC: begin
        if (g_rd_q[SW]) begin
          f_we = 1'b1; f_wa = g_rd_q[SW-1:0]; f_wd = '0;
          q_we = 1'b1; q_wa = tail_q[SW-1:0]; q_wd = g_rd_q[SW-1:0];
          tail_d = tail_q + 1'b1;
        end else begin
          g_we = 1'b1; g_wa = gaddr('0, a_q); g_wd = {1'b1, {SW{1'b0}}};
        end
        if (a_q == AW'(ALPHABET - 1)) begin
          state_d = S_B_QCHK;
        end else begin
          a_d  = a_q + 1'b1;
          g_ra = gaddr('0, a_q + 1'b1);
        end
      end
      S_B_QCHK: begin
        if (head_q < tail_q) begin
          q_ra    = head_q[SW-1:0];
          state_d = S_B_QR;
        end else begin
          clr_d   = '0;
          state_d = S_B_CLR;
        end
      end
      S_B_QR: begin
        r_d     = q_rd_q;
        head_d  = head_q + 1'b1;
        f_ra    = q_rd_q;
        state_d = S_B_F;
      end
      S_B_F: begin
        fr_d    = f_rd_q;
        a_d     = '0;
        g_ra    = gaddr(r_q, '0);
        state_d = S_B_G;
      end
      S_B_G: begin
        if (g_rd_q[SW]) begin
          c_d = g_rd_q[SW-1:0];
          if (tail_q < (SW+1)'(MAX_STATES)) begin
            q_we = 1'b1; q_wa = tail_q[SW-1:0]; q_wd = g_rd_q[SW-1:0];
            tail_d = tail_q + 1'b1;
          end
          f_d     = fr_q;
          g_ra    = gaddr(fr_q, a_q);
          state_d = S_B_FW;
        end else begin
          adv_a = 1'b1;
        end
      end
      S_B_FW: begin
        if (g_rd_q[SW]) begin
          f_d  = g_rd_q[SW-1:0];
          f_we = 1'b1; f_wa = c_q; f_wd = g_rd_q[SW-1:0];
          l_ra    = g_rd_q[SW-1:0];
          state_d = S_B_LF;
        end else begin
          f_ra    = f_q;
          state_d = S_B_FF;
        end
      end
      S_B_FF: begin
        f_d     = f_rd_q;
        g_ra    = gaddr(f_rd_q, a_q);
        state_d = S_B_FW;
      end
      S_B_LF: begin
        lf_d    = l_rd_q;
        l_ra    = c_q;
        state_d = S_B_LC;
      end
      S_B_LC: begin
        bn    = l_rd_q;
        bk    = '0;
        bstep = 1'b1;
      end
      S_B_ID: begin
        i_we = 1'b1; i_wa = iaddr(c_q, n_q); i_wd = i_rd_q;
        l_we = 1'b1; l_wa = c_q; l_wd = n_q + 1'b1;
        bn    = n_q + 1'b1;
        bk    = k_q + 1'b1;
        bstep = 1'b1;
      end
      S_B_CLR: begin
        h_we = 1'b1; h_wa = clr_q[PW-1:0];
        if (clr_q == CLW'(MAX_PATTERNS - 1)) begin
          built_d  = 1'b1;
          cur_d    = '0;
          scan_d   = '0;
          done_d   = 1'b1;
          status_d = bst_q ? mpsm_pkg::ST_OUTPUT_FULL : mpsm_pkg::ST_OK;
          state_d  = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      default: state_d = S_INIT;
    endcase

    // copy the failure state's ids into the child, drop what does not fit
    if (bstep) begin
      n_d = bn;
      k_d = bk;
      if (bk < lf_q) begin
        if (bn >= LW'(OUTPUTS_PER_STATE)) begin
          bst_d = 1'b1;
          adv_a = 1'b1;
        end else begin
          i_ra    = iaddr(f_q, bk);
          state_d = S_B_ID;
        end
      end else begin
        adv_a = 1'b1;
      end
    end

    if (adv_a) begin
      if (a_q == AW'(ALPHABET - 1)) begin
        state_d = S_B_QCHK;
      end else begin
        a_d     = a_q + 1'b1;
        g_ra    = gaddr(r_q, a_q + 1'b1);
        state_d = S_B_G;
      end
    end

    if (sstep) begin
      kn = k_q + 1'b1;
      if (kn == n_q) begin
        done_d  = 1'b1;
        cs_d    = show(s_q);
        mh_d    = cnt3(n_q);
        state_d = S_IDLE;
      end else begin
        k_d     = kn;
        i_ra    = iaddr(s_q, kn);
        state_d = S_S_ID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      clr_q    <= '0;
      pcnt_q   <= mpsm_pkg::PCOUNT_RESET;
      nfs_q    <= (SW+1)'(1);
      head_q   <= '0;
      tail_q   <= '0;
      cur_q    <= '0;
      scan_q   <= '0;
      s_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      f_q      <= '0;
      fr_q     <= '0;
      built_q  <= 1'b0;
      last_q   <= 1'b0;
      bst_q    <= 1'b0;
      a_q      <= '0;
      pid_q    <= '0;
      n_q      <= '0;
      k_q      <= '0;
      lf_q     <= '0;
      id_q     <= '0;
      done_q   <= 1'b0;
      status_q <= mpsm_pkg::ST_OK;
      cs_q     <= '0;
      mh_q     <= '0;
      hc_q     <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pcnt_q   <= pcnt_d;
      nfs_q    <= nfs_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      scan_q   <= scan_d;
      s_q      <= s_d;
      r_q      <= r_d;
      c_q      <= c_d;
      f_q      <= f_d;
      fr_q     <= fr_d;
      built_q  <= built_d;
      last_q   <= last_d;
      bst_q    <= bst_d;
      a_q      <= a_d;
      pid_q    <= pid_d;
      n_q      <= n_d;
      k_q      <= k_d;
      lf_q     <= lf_d;
      id_q     <= id_d;
      done_q   <= done_d;
      status_q <= status_d;
      cs_q     <= cs_d;
      mh_q     <= mh_d;
      hc_q     <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      goto_mem[g_wa] <= g_wd;
    end
    g_rd_q <= goto_mem[g_ra];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fail_mem[f_wa] <= f_wd;
    end
    f_rd_q <= fail_mem[f_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      len_mem[l_wa] <= l_wd;
    end
    l_rd_q <= len_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      ids_mem[i_wa] <= i_wd;
    end
    i_rd_q <= ids_mem[i_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    q_rd_q <= queue_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hit_mem[h_wa] <= h_wd;
    end
    h_rd_q <= hit_mem[h_ra];
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign current_state_o = cs_q;
  assign matches_here_o  = mh_q;
  assign hit_count_o     = hc_q;

endmodule

/* hw/rtl/mpsm_checker.sv */
// Port-level checker for the string matcher, bound to the top level.
`include "multi_pattern_string_matcher_assert.svh"

module mpsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [2:0]  matches_here_o,
  input logic [31:0] hit_count_o
);

  `MPSM_ASSERT_NOW(a_status_code, done_o, status_o == mpsm_pkg::ST_OK || status_o == mpsm_pkg::ST_STATES_FULL || status_o == mpsm_pkg::ST_OUTPUT_FULL || status_o == mpsm_pkg::ST_PHASE || status_o == mpsm_pkg::ST_RANGE, "status code out of range")
  `MPSM_ASSERT_NEXT(a_start_answered, start && !busy, done_o || busy, "accepted word neither answered nor in progress")
  `MPSM_ASSERT_NOW(a_error_clean, done_o && status_o != mpsm_pkg::ST_OK, hit_count_o == 32'd0 && matches_here_o == 3'd0, "error result carries payload")

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (.*);

/* bench/multi_pattern_string_matcher_tb.sv */
// Self-checking bench for the multi-pattern string matcher: trie fill, build, scan and counter reads.
module multi_pattern_string_matcher_tb;

  localparam int NSYM = 4;
  localparam int NST = 1024;
  localparam int NPAT = 256;
  localparam int NOUT = 4;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    mpsm_pkg::status_e st;
    logic [9:0]        state;
    logic [2:0]        nmatch;
    logic [31:0]       hits;
  } match_word_t;

  typedef struct {
    mpsm_pkg::mode_e   mode;
    logic [7:0]        sym;
    logic [7:0]        pid;
    logic              last;
    bit                typed;
    mpsm_pkg::status_e st;
    logic [9:0]        state;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [7:0]  symbol_i = '0;
  logic [7:0]  pattern_id_i = '0;
  logic        last_symbol_i = 1'b0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [9:0]  current_state_o;
  logic [2:0]  matches_here_o;
  logic [31:0] hit_count_o;

  bit          trie_edge[NST*NSYM];
  int          trie_next[NST*NSYM];
  int          fail_to[NST];
  logic [7:0]  id_list[NST*NOUT];
  int          id_len[NST];
  logic [31:0] hit_ctr[NPAT];
  int          free_state;
  int          ins_pos;
  int          scan_pos;
  bit          is_built;
  int          bfs_q[NST];
  int          pat_in_use;

  match_word_t pending_words[$];
  int          fails;
  int          cycles;
  int          n_words;
  int          n_full_states;
  int          n_scans;
  bit          idle_en;

  multi_pattern_string_matcher u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .mode_i, .symbol_i, .pattern_id_i, .last_symbol_i,
    .done_o, .status_o, .current_state_o, .matches_here_o, .hit_count_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic match_word_t match_step(mpsm_pkg::mode_e m, int sym, int pid, bit last);
    match_word_t w;
    int idx, s, f, n, head, tail, r, c, used;
    w = '{st: mpsm_pkg::ST_OK, state: '0, nmatch: '0, hits: '0};
    used = (pat_in_use < NPAT) ? pat_in_use : NPAT;
    case (m)
      mpsm_pkg::MODE_ADD: begin
        w.state = ins_pos[9:0];
        if (is_built) begin
          w.st = mpsm_pkg::ST_PHASE;
        end else if (sym >= NSYM) begin
          w.st = mpsm_pkg::ST_RANGE;
        end else begin
          idx = ins_pos * NSYM + sym;
          if (!trie_edge[idx] && free_state >= NST) begin
            w.st = mpsm_pkg::ST_STATES_FULL;
            ins_pos = 0;
          end else begin
            if (!trie_edge[idx]) begin
              trie_edge[idx] = 1'b1;
              trie_next[idx] = free_state;
              free_state++;
            end
            s = trie_next[idx];
            ins_pos = s;
            w.state = s[9:0];
            if (last) begin
              ins_pos = 0;
              if (id_len[s] >= NOUT) begin
                w.st = mpsm_pkg::ST_OUTPUT_FULL;
              end else begin
                id_list[s*NOUT + id_len[s]] = pid[7:0];
                id_len[s]++;
              end
            end
          end
        end
      end
      mpsm_pkg::MODE_BUILD: begin
        if (is_built) begin
          w.st = mpsm_pkg::ST_PHASE;
        end else begin
          head = 0;
          tail = 0;
          for (int a = 0; a < NSYM; a++) begin
            if (trie_edge[a]) begin
              fail_to[trie_next[a]] = 0;
              bfs_q[tail++] = trie_next[a];
            end else begin
              trie_edge[a] = 1'b1;
              trie_next[a] = 0;
            end
          end
          while (head < tail) begin
            r = bfs_q[head++];
            for (int a = 0; a < NSYM; a++) begin
              if (trie_edge[r*NSYM + a]) begin
                c = trie_next[r*NSYM + a];
                if (tail < NST) bfs_q[tail++] = c;
                f = fail_to[r];
                while (!trie_edge[f*NSYM + a]) f = fail_to[f];
                f = trie_next[f*NSYM + a];
                fail_to[c] = f;
                for (int k = 0; k < id_len[f]; k++) begin
                  n = id_len[c];
                  if (n >= NOUT) begin
                    w.st = mpsm_pkg::ST_OUTPUT_FULL;
                    break;
                  end
                  id_list[c*NOUT + n] = id_list[f*NOUT + k];
                  id_len[c] = n + 1;
                end
              end
            end
          end
          foreach (hit_ctr[i]) hit_ctr[i] = '0;
          is_built = 1'b1;
          ins_pos = 0;
          scan_pos = 0;
        end
      end
      mpsm_pkg::MODE_SCAN: begin
        if (!is_built) begin
          w.st = mpsm_pkg::ST_PHASE;
        end else if (sym >= NSYM) begin
          w.st = mpsm_pkg::ST_RANGE;
        end else begin
          s = scan_pos;
          while (!trie_edge[s*NSYM + sym]) s = fail_to[s];
          s = trie_next[s*NSYM + sym];
          scan_pos = s;
          for (int k = 0; k < id_len[s]; k++) begin
            idx = id_list[s*NOUT + k];
            if (idx < used && hit_ctr[idx] != 32'hFFFF_FFFF) hit_ctr[idx]++;
          end
          w.nmatch = id_len[s][2:0];
        end
        w.state = scan_pos[9:0];
      end
      default: begin
        if (pid < used) w.hits = hit_ctr[pid];
        else w.st = mpsm_pkg::ST_RANGE;
        w.state = scan_pos[9:0];
      end
    endcase
    return w;
  endfunction

  // issue one word; called just after a falling edge, returns just after one
  task automatic issue(mpsm_pkg::mode_e m, int sym, int pid, bit last, bit typed = 0,
                       mpsm_pkg::status_e tst = mpsm_pkg::ST_OK, int tstate = 0);
    match_word_t w;
    int gap;
    mode_i = m;
    symbol_i = sym[7:0];
    pattern_id_i = pid[7:0];
    last_symbol_i = last;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    w = match_step(m, sym, pid, last);
    if (w.st == mpsm_pkg::ST_STATES_FULL) n_full_states++;
    if (m == mpsm_pkg::MODE_SCAN) n_scans++;
    if (typed) w = '{st: tst, state: tstate[9:0], nmatch: '0, hits: '0};
    pending_words.push_back(w);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_pattern_count(int v);
    drain();
    cfg_wdata_i = v[8:0];
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pat_in_use = v & 'h1FF;
  endtask

  always @(posedge clk_i) begin
    match_word_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && done_o) begin
      n_words++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: status %0d state %0d", status_o, current_state_o);
        fails++;
      end else begin
        w = pending_words.pop_front();
        if (status_o !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status_o);
          fails++;
        end
        if (current_state_o !== w.state) begin
          $error("current_state: expected %0d, got %0d", w.state, current_state_o);
          fails++;
        end
        if (matches_here_o !== w.nmatch) begin
          $error("matches_here: expected %0d, got %0d", w.nmatch, matches_here_o);
          fails++;
        end
        if (hit_count_o !== w.hits) begin
          $error("hit_count: expected %0d, got %0d", w.hits, hit_count_o);
          fails++;
        end
      end
    end
  end

  initial begin
    stim_row_t pre_rows[$];
    stim_row_t post_rows[$];
    int plen, r, items, wait_cyc;
    int counts[5];
    foreach (trie_edge[i]) trie_edge[i] = 1'b0;
    foreach (trie_next[i]) trie_next[i] = 0;
    foreach (fail_to[i]) fail_to[i] = 0;
    foreach (id_len[i]) id_len[i] = 0;
    foreach (hit_ctr[i]) hit_ctr[i] = '0;
    free_state = 1;
    ins_pos = 0;
    scan_pos = 0;
    is_built = 1'b0;
    pat_in_use = 256;
    fails = 0;
    cycles = 0;
    n_words = 0;
    n_full_states = 0;
    n_scans = 0;
    idle_en = 1'b1;

    pre_rows = '{
      '{mpsm_pkg::MODE_SCAN, 8'd0, 8'd0, 1'b0, 1, mpsm_pkg::ST_PHASE, 0},
      '{mpsm_pkg::MODE_ADD, 8'd7, 8'd0, 1'b1, 1, mpsm_pkg::ST_RANGE, 0},
      '{mpsm_pkg::MODE_ADD, 8'd255, 8'd255, 1'b0, 1, mpsm_pkg::ST_RANGE, 0},
      '{mpsm_pkg::MODE_READ, 8'd0, 8'd255, 1'b0, 1, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd0, 8'd0, 1'b1, 1, mpsm_pkg::ST_OK, 1},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd1, 1'b1, 1, mpsm_pkg::ST_OK, 2},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd2, 1'b1, 1, mpsm_pkg::ST_OK, 2},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd3, 1'b1, 1, mpsm_pkg::ST_OK, 2},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd4, 1'b1, 1, mpsm_pkg::ST_OK, 2},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd5, 1'b1, 1, mpsm_pkg::ST_OUTPUT_FULL, 2},
      '{mpsm_pkg::MODE_ADD, 8'd1, 8'd0, 1'b0, 0, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd0, 8'd6, 1'b1, 0, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd1, 8'd0, 1'b0, 0, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd3, 8'd7, 1'b1, 0, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd2, 8'd170, 1'b0, 0, mpsm_pkg::ST_OK, 0},
      '{mpsm_pkg::MODE_ADD, 8'd2, 8'd85, 1'b1, 0, mpsm_pkg::ST_OK, 0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    set_pattern_count(256);

    foreach (pre_rows[i])
      issue(pre_rows[i].mode, pre_rows[i].sym, pre_rows[i].pid, pre_rows[i].last,
            pre_rows[i].typed, pre_rows[i].st, pre_rows[i].state);

    // grow the trie until it has overflowed six times or 1500 items are issued
    items = 0;
    while ((n_full_states < 6) && items < 1500) begin
      plen = $urandom_range(24, 64);
      for (int k = 0; k < plen; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) issue(mpsm_pkg::MODE_ADD, $urandom_range(0, 255), $urandom_range(0, 255), 0);
        else if (r < 5) issue(mpsm_pkg::MODE_SCAN, $urandom_range(0, 255), 0,
                              $urandom_range(0, 1));
        else if (r < 7) issue(mpsm_pkg::MODE_READ, $urandom_range(0, 255),
                              $urandom_range(0, 255), 0);
        else issue(mpsm_pkg::MODE_ADD, $urandom_range(0, NSYM-1), $urandom_range(0, 255),
                   k == plen-1);
        items++;
      end
    end
    // leave a pattern unfinished across the build
    issue(mpsm_pkg::MODE_ADD, 1, 0, 0);
    issue(mpsm_pkg::MODE_ADD, 2, 0, 0);
    drain();
    issue(mpsm_pkg::MODE_BUILD, 0, 0, 0);
    drain();

    post_rows = '{
      '{mpsm_pkg::MODE_ADD, 8'd0, 8'd0, 1'b1, 1, mpsm_pkg::ST_PHASE, 0},
      '{mpsm_pkg::MODE_BUILD, 8'd0, 8'd0, 1'b0, 1, mpsm_pkg::ST_PHASE, 0},
      '{mpsm_pkg::MODE_SCAN, 8'd4, 8'd0, 1'b0, 1, mpsm_pkg::ST_RANGE, 0},
      '{mpsm_pkg::MODE_READ, 8'd0, 8'd1, 1'b0, 1, mpsm_pkg::ST_RANGE, 0},
      '{mpsm_pkg::MODE_READ, 8'd0, 8'd0, 1'b0, 1, mpsm_pkg::ST_OK, 0}
    };
    set_pattern_count(1);
    foreach (post_rows[i])
      issue(post_rows[i].mode, post_rows[i].sym, post_rows[i].pid, post_rows[i].last,
            post_rows[i].typed, post_rows[i].st, post_rows[i].state);

    counts = '{1, 511, 256, 255, $urandom_range(1, 300)};
    foreach (counts[p]) begin
      set_pattern_count(counts[p]);
      if (p == 4) idle_en = 1'b0;
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        if (r < 78) issue(mpsm_pkg::MODE_SCAN, $urandom_range(0, NSYM-1),
                          $urandom_range(0, 255), $urandom_range(0, 1));
        else if (r < 94) issue(mpsm_pkg::MODE_READ, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 1));
        else if (r < 97) issue(mpsm_pkg::MODE_SCAN, $urandom_range(0, 255), 0, 0);
        else issue(mpsm_pkg::mode_e'($urandom_range(0, 1)), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 1));
      end
    end

    start = 1'b0;
    wait_cyc = 0;
    while (pending_words.size() != 0 && wait_cyc < 200000) begin
      @(negedge clk_i);
      wait_cyc++;
    end
    repeat (50) @(negedge clk_i);
    $display("covered %0d words: %0d trie states, %0d table-full adds, %0d scans",
             n_words, free_state, n_full_states, n_scans);
    $display("build, phase and range errors, and five counter widths were exercised");
    if (fails == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* multi_pattern_string_matcher.f */
+incdir+hw/rtl
hw/rtl/mpsm_pkg.sv
hw/rtl/multi_pattern_string_matcher.sv
hw/rtl/mpsm_checker.sv
bench/multi_pattern_string_matcher_tb.sv
